>>> sv/histogram_mtf_stretch_core_assert.svh
// Assertion macros shared by the histogram MTF stretch RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef HISTOGRAM_MTF_STRETCH_CORE_ASSERT_SVH
`define HISTOGRAM_MTF_STRETCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HMTF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hmtf assertion failed");

// Next-cycle implication, disabled during reset.
`define HMTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hmtf assertion failed");

`endif

>>> sv/hmtf_pkg.sv
// Shared types and constants of the histogram MTF stretch block.
// No dependencies; imported by every module of the block.
package hmtf_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHADOWS    = 3'd0,
        REG_HIGHLIGHTS = 3'd1,
        REG_MIDTONES   = 3'd2,
        REG_OUT_LOW    = 3'd3,
        REG_OUT_HIGH   = 3'd4
    } t_reg_idx;

    // Pixel class: clipped to low end, clipped to high end, or computed.
    typedef enum logic [2:0] {
        CLS_LO  = 3'b001,
        CLS_HI  = 3'b010,
        CLS_MID = 3'b100
    } t_cls;

    // Control that travels with each word down the pipe.
    typedef struct packed {
        logic valid;
        t_cls cls;
    } t_fwd;

endpackage

>>> sv/hmtf_front.sv
// Front end: classify pixel, rescale, and form MTF numerator and denominator.
// Four registered stages; uses hmtf_pkg and the assertion macro header.
`include "histogram_mtf_stretch_core_assert.svh"

module hmtf_front
    import hmtf_pkg::*;
#(
    parameter int PIXEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [PIXEL_BITS-1:0]   i_pixel,
    input  logic [PIXEL_BITS-1:0]   i_shadows,
    input  logic [PIXEL_BITS-1:0]   i_highlights,
    input  logic [PIXEL_BITS-1:0]   i_midtones,
    output t_fwd                    o_fwd,
    output logic [2*PIXEL_BITS-1:0] o_num,
    output logic [2*PIXEL_BITS-1:0] o_den,
    input  logic                    i_ready
);

    localparam int PW = PIXEL_BITS;
    localparam int DW = 2 * PIXEL_BITS;
    localparam logic [PW-1:0] FULL_SCALE = {PW{1'b1}};
    localparam logic [PW-1:0] HALF_CODE  = {1'b1, {(PW-1){1'b0}}};

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // stage 1: class, offset a = p - s, range r = h - s
    t_fwd            r1_fwd;
    logic [PW-1:0]   r1_a, r1_r;
    t_cls            n1_cls;

    // stage 2: |r - 2a| and its sign
    t_fwd            r2_fwd;
    logic [PW-1:0]   r2_a, r2_r;
    logic [PW:0]     r2_d;
    logic            r2_neg;
    logic [PW:0]     w_a2, w_r_ext, n2_d;
    logic            n2_neg;

    // stage 3: products
    t_fwd            r3_fwd;
    logic [PW-1:0]   r3_a, r3_r;
    logic            r3_neg, r3_half;
    logic [DW-1:0]   r3_mul1, r3_fa;
    logic [DW:0]     r3_mul2;

    // stage 4: num / den
    t_fwd            r4_fwd;
    logic [DW-1:0]   r4_num, r4_den;
    logic [DW:0]     w_den_full;

    assign w_rdy4  = ~r4_fwd.valid | i_ready;
    assign w_rdy3  = ~r3_fwd.valid | w_rdy4;
    assign w_rdy2  = ~r2_fwd.valid | w_rdy3;
    assign w_rdy1  = ~r1_fwd.valid | w_rdy2;
    assign o_ready = w_rdy1;

    always_comb begin
        if (i_pixel <= i_shadows) begin
            n1_cls = CLS_LO;
        end else if (i_pixel >= i_highlights) begin
            n1_cls = CLS_HI;
        end else begin
            n1_cls = CLS_MID;
        end
    end

    assign w_a2    = {r1_a, 1'b0};
    assign w_r_ext = {1'b0, r1_r};
    assign n2_neg  = w_r_ext < w_a2;
    assign n2_d    = n2_neg ? (w_a2 - w_r_ext) : (w_r_ext - w_a2);

    assign w_den_full = r3_neg ? ({1'b0, r3_fa} - r3_mul2) : ({1'b0, r3_fa} + r3_mul2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_fwd.valid <= 1'b0;
            r2_fwd.valid <= 1'b0;
            r3_fwd.valid <= 1'b0;
            r4_fwd.valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r1_fwd.valid <= i_valid;
                r1_fwd.cls   <= n1_cls;
            end
            if (w_rdy2) begin
                r2_fwd <= r1_fwd;
            end
            if (w_rdy3) begin
                r3_fwd <= r2_fwd;
            end
            if (w_rdy4) begin
                r4_fwd <= r3_fwd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_a <= i_pixel - i_shadows;
            r1_r <= i_highlights - i_shadows;
        end
        if (w_rdy2) begin
            r2_a   <= r1_a;
            r2_r   <= r1_r;
            r2_d   <= n2_d;
            r2_neg <= n2_neg;
        end
        if (w_rdy3) begin
            r3_a    <= r2_a;
            r3_r    <= r2_r;
            r3_neg  <= r2_neg;
            r3_half <= (i_midtones == HALF_CODE);
            r3_mul1 <= {{PW{1'b0}}, FULL_SCALE - i_midtones} * {{PW{1'b0}}, r2_a};
            r3_mul2 <= {{(PW+1){1'b0}}, i_midtones} * {{PW{1'b0}}, r2_d};
            r3_fa   <= {r2_a, {PW{1'b0}}} - {{PW{1'b0}}, r2_a};
        end
        if (w_rdy4) begin
            if (r3_half) begin
                r4_num <= {{PW{1'b0}}, r3_a};
                r4_den <= {{PW{1'b0}}, r3_r};
            end else begin
                r4_num <= r3_mul1;
                r4_den <= w_den_full[DW-1:0];
            end
        end
    end

    assign o_fwd = r4_fwd;
    assign o_num = r4_num;
    assign o_den = r4_den;

    `HMTF_ASSERT_NOW(a_num_le_den, i_clk, i_rst_n,
        r4_fwd.valid && (r4_fwd.cls == CLS_MID), r4_num <= r4_den)
    `HMTF_ASSERT_NOW(a_den_nonzero, i_clk, i_rst_n,
        r4_fwd.valid && (r4_fwd.cls == CLS_MID), r4_den != '0)

endmodule

>>> sv/hmtf_cell.sv
// One cell of the scaling chain: folds one span bit into q and remainder.
// Uses hmtf_pkg and the assertion macro header.
`include "histogram_mtf_stretch_core_assert.svh"

module hmtf_cell
    import hmtf_pkg::*;
#(
    parameter int PIXEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_fwd                    i_fwd,
    output logic                    o_ready,
    input  logic [2*PIXEL_BITS-1:0] i_num,
    input  logic [2*PIXEL_BITS-1:0] i_den,
    input  logic [2*PIXEL_BITS-1:0] i_rem,
    input  logic [PIXEL_BITS-1:0]   i_q,
    input  logic                    i_span_bit,
    output t_fwd                    o_fwd,
    output logic [2*PIXEL_BITS-1:0] o_num,
    output logic [2*PIXEL_BITS-1:0] o_den,
    output logic [2*PIXEL_BITS-1:0] o_rem,
    output logic [PIXEL_BITS-1:0]   o_q,
    input  logic                    i_ready
);

    localparam int PW = PIXEL_BITS;
    localparam int DW = 2 * PIXEL_BITS;

    t_fwd           r_fwd;
    logic [DW-1:0]  r_num, r_den, r_rem;
    logic [PW-1:0]  r_q;

    logic [DW+1:0]  w_t, w_den1, w_den2, w_tr;
    logic [1:0]     w_k;
    logic [PW:0]    w_qx;
    logic [DW-1:0]  n_rem;
    logic [PW-1:0]  n_q;

    // t = 2*rem + bit*num < 3*den, so one of three quotient digits 0..2
    assign w_t    = {1'b0, i_rem, 1'b0} + (i_span_bit ? {2'b00, i_num} : '0);
    assign w_den1 = {2'b00, i_den};
    assign w_den2 = {1'b0, i_den, 1'b0};

    always_comb begin
        if (w_t >= w_den2) begin
            w_tr = w_t - w_den2;
            w_k  = 2'd2;
        end else if (w_t >= w_den1) begin
            w_tr = w_t - w_den1;
            w_k  = 2'd1;
        end else begin
            w_tr = w_t;
            w_k  = 2'd0;
        end
    end

    assign w_qx  = {i_q, 1'b0} + {{(PW-1){1'b0}}, w_k};
    assign n_rem = w_tr[DW-1:0];
    assign n_q   = w_qx[PW-1:0];

    assign o_ready = ~r_fwd.valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd.valid <= 1'b0;
        end else if (o_ready) begin
            r_fwd <= i_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_fwd = r_fwd;
    assign o_num = r_num;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_q   = r_q;

    `HMTF_ASSERT_NOW(a_rem_lt_den, i_clk, i_rst_n,
        r_fwd.valid && (r_fwd.cls == CLS_MID), r_rem < r_den)

endmodule

>>> sv/hmtf_round.sv
// Output stage: round the scaled quotient, offset from output low, select ends.
// Uses hmtf_pkg and the assertion macro header; holds the output register.
`include "histogram_mtf_stretch_core_assert.svh"

module hmtf_round
    import hmtf_pkg::*;
#(
    parameter int PIXEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_fwd                    i_fwd,
    output logic                    o_ready,
    input  logic [2*PIXEL_BITS-1:0] i_num,
    input  logic [2*PIXEL_BITS-1:0] i_rem,
    input  logic [2*PIXEL_BITS-1:0] i_den,
    input  logic [PIXEL_BITS-1:0]   i_q,
    input  logic [PIXEL_BITS-1:0]   i_out_low,
    input  logic [PIXEL_BITS-1:0]   i_out_high,
    input  logic                    i_up,
    output logic                    o_valid,
    output logic [PIXEL_BITS-1:0]   o_pixel,
    input  logic                    i_ready
);

    localparam int PW = PIXEL_BITS;
    localparam int DW = 2 * PIXEL_BITS;

    logic           r_valid;
    logic [PW-1:0]  r_pixel;

    logic [DW:0]    w_rem2, w_den_ext;
    logic           w_rnd;
    logic [PW-1:0]  w_qr;
    logic [PW-1:0]  n_pixel;

    assign w_rem2    = {i_rem, 1'b0};
    assign w_den_ext = {1'b0, i_den};
    // ties round the quotient up on a rising map, down on an inverted one
    assign w_rnd     = i_up ? (w_rem2 >= w_den_ext) : (w_rem2 > w_den_ext);
    assign w_qr      = i_q + {{(PW-1){1'b0}}, w_rnd};

    always_comb begin
        case (i_fwd.cls)
            CLS_LO:  n_pixel = i_out_low;
            CLS_HI:  n_pixel = i_out_high;
            default: n_pixel = i_up ? (i_out_low + w_qr) : (i_out_low - w_qr);
        endcase
    end

    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_fwd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

    // scaled fraction stays within 0..1 all the way down the chain
    `HMTF_ASSERT_NOW(a_tail_num_le_den, i_clk, i_rst_n,
        i_fwd.valid && (i_fwd.cls == CLS_MID), i_num <= i_den)
    `HMTF_ASSERT_NOW(a_tail_rem_lt_den, i_clk, i_rst_n,
        i_fwd.valid && (i_fwd.cls == CLS_MID), i_rem < i_den)

endmodule

>>> sv/histogram_mtf_stretch_core.sv
// Histogram transformation with midtones transfer function, top level.
// Instantiates hmtf_front, a chain of hmtf_cell and hmtf_round; uses hmtf_pkg.
//
// Usage:
//   Pixel words enter on i_pixel_in with i_in_valid / o_in_ready and leave on
//   o_pixel_out with o_out_valid / i_out_ready. A word moves when valid and
//   ready are both high at a rising edge of i_clk.
//   Settings are written on the cfg channel (i_cfg_index, i_cfg_data); the
//   channel always takes a word. Write only while the pipe is empty.
//   Indexes: 0 shadows, 1 highlights, 2 midtones, 3 output low, 4 output high;
//   other indexes are ignored.
// Timing:
//   One word per clock sustained while i_out_ready stays high. The pipe holds four front
//   stages (class/offset, |r-2a|, products, num/den), one cell per span bit
//   doing a radix-2 scaled division, and the rounding output register.
//   Every stage has its own valid bit and a ready chain, so bubbles collapse
//   and input is still taken while a result waits on a stalled receiver; a
//   full pipe holds every word in place until i_out_ready returns.
// Reset:
//   Synchronous active-low i_rst_n empties the pipe and loads the identity
//   settings (shadows 0, highlights full scale, midtones one half, output
//   range full scale).
module histogram_mtf_stretch_core
    import hmtf_pkg::*;
#(
    parameter int PIXEL_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel_in,
    // pixel output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIXEL_BITS-1:0] o_pixel_out,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [PIXEL_BITS-1:0] i_cfg_data
);

    localparam int PW = PIXEL_BITS;
    localparam int DW = 2 * PIXEL_BITS;
    localparam logic [PW-1:0] FULL_SCALE = {PW{1'b1}};
    localparam logic [PW-1:0] HALF_CODE  = {1'b1, {(PW-1){1'b0}}};

    // settings
    logic [PW-1:0] r_shadows, r_highlights, r_midtones, r_out_low, r_out_high;

    // output span and direction; the user must change settings only with the pipe empty (unenforced)
    logic          w_up;
    logic [PW-1:0] w_span;

    // chain links: index 0 is the front end output, index PW the last cell
    t_fwd          w_fwd [0:PW];
    logic [DW-1:0] w_num [0:PW];
    logic [DW-1:0] w_den [0:PW];
    logic [DW-1:0] w_rem [0:PW];
    logic [PW-1:0] w_q   [0:PW];
    logic          w_rdy [0:PW];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadows    <= '0;
            r_highlights <= FULL_SCALE;
            r_midtones   <= HALF_CODE;
            r_out_low    <= '0;
            r_out_high   <= FULL_SCALE;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SHADOWS:    r_shadows    <= i_cfg_data;
                REG_HIGHLIGHTS: r_highlights <= i_cfg_data;
                REG_MIDTONES:   r_midtones   <= i_cfg_data;
                REG_OUT_LOW:    r_out_low    <= i_cfg_data;
                REG_OUT_HIGH:   r_out_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_up   = r_out_high >= r_out_low;
    assign w_span = w_up ? (r_out_high - r_out_low) : (r_out_low - r_out_high);

    hmtf_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_pixel      (i_pixel_in),
        .i_shadows    (r_shadows),
        .i_highlights (r_highlights),
        .i_midtones   (r_midtones),
        .o_fwd        (w_fwd[0]),
        .o_num        (w_num[0]),
        .o_den        (w_den[0]),
        .i_ready      (w_rdy[0])
    );

    // quotient and remainder start at zero
    assign w_rem[0] = '0;
    assign w_q[0]   = '0;

    // cell k takes span bit PW-1-k, most significant first
    for (genvar k = 0; k < PW; k++) begin : g_cell
        hmtf_cell #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_fwd      (w_fwd[k]),
            .o_ready    (w_rdy[k]),
            .i_num      (w_num[k]),
            .i_den      (w_den[k]),
            .i_rem      (w_rem[k]),
            .i_q        (w_q[k]),
            .i_span_bit (w_span[PW-1-k]),
            .o_fwd      (w_fwd[k+1]),
            .o_num      (w_num[k+1]),
            .o_den      (w_den[k+1]),
            .o_rem      (w_rem[k+1]),
            .o_q        (w_q[k+1]),
            .i_ready    (w_rdy[k+1])
        );
    end

    // the numerator leaving the chain is range-checked again in the output stage, as in the front end
    hmtf_round #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fwd      (w_fwd[PW]),
        .o_ready    (w_rdy[PW]),
        .i_num      (w_num[PW]),
        .i_rem      (w_rem[PW]),
        .i_den      (w_den[PW]),
        .i_q        (w_q[PW]),
        .i_out_low  (r_out_low),
        .i_out_high (r_out_high),
        .i_up       (w_up),
        .o_valid    (o_out_valid),
        .o_pixel    (o_pixel_out),
        .i_ready    (i_out_ready)
    );

endmodule
